// File: rtl/core/psg_pkg.sv
`timescale 1ns / 1ps
package psg_pkg;

   // voice count; the noise channel occupies slot VOICES of the recompute walk
   localparam int VOICES = 3;
   localparam int VI_W   = $clog2(VOICES + 1);

   // field widths
   localparam int CMD_W       = 2;
   localparam int REG_IDX_W   = 4;
   localparam int BYTE_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RATE_W      = 16;
   localparam int LEVEL_W     = 4;
   localparam int PERIOD_W    = 12;
   localparam int NPER_W      = 5;
   localparam int STEP_W      = 32;
   localparam int AMP_W       = 7;
   localparam int MIX_W       = 10;
   localparam int PROD_W      = 17;
   localparam int NSHIFT_W    = 17;
   localparam int NCOUNT_W    = 16;
   localparam int NSIGN_W     = 2;

   // commands
   localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RECOMPUTE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_VOLUME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_ENABLE  = 2'd2;

   // chip register addresses
   localparam logic [REG_IDX_W-1:0] REG_NOISE_PERIOD = 4'd6;
   localparam logic [REG_IDX_W-1:0] REG_MIXER        = 4'd7;
   localparam logic [REG_IDX_W-1:0] REG_LEVEL_BASE   = 4'd8;

   // noise sign codes
   localparam logic [NSIGN_W-1:0] NSIGN_NONE  = 2'd0;
   localparam logic [NSIGN_W-1:0] NSIGN_PLUS  = 2'd1;
   localparam logic [NSIGN_W-1:0] NSIGN_MINUS = 2'd3;

   // reset values
   localparam logic [RATE_W-1:0]   RATE_RESET     = 16'd22050;
   localparam logic [BYTE_W-1:0]   MVOL_RESET     = 8'd64;
   localparam logic [NSHIFT_W-1:0] NOISE_SEED     = 17'h01234;
   localparam logic [NCOUNT_W-1:0] NOISE_IV_RESET = 16'd100;
   localparam logic [BYTE_W-1:0]   DAC_MID        = 8'd128;

   // divider
   localparam int DIV_NUM_W = 50;
   localparam int DIV_DEN_W = 28;
   localparam int DIV_STEPS = DIV_NUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [21:0] CHIP_CLOCK  = 22'd3579545;
   localparam logic [13:0] TOP_FREQ    = 14'd10000;
   localparam logic [PERIOD_W-1:0] FAST_PERIOD = 12'd22;

   localparam logic [DIV_NUM_W-1:0] VOICE_NUM = DIV_NUM_W'(CHIP_CLOCK) << 28;
   localparam logic [DIV_NUM_W-1:0] TOP_NUM   = DIV_NUM_W'(TOP_FREQ) << 32;

   // floor(level * 127 / 15)
   function automatic logic [AMP_W-1:0] level_amp(input logic [LEVEL_W-1:0] level);
      logic [AMP_W-1:0] amp;
      unique case (level)
         4'd0:  amp = 7'd0;
         4'd1:  amp = 7'd8;
         4'd2:  amp = 7'd16;
         4'd3:  amp = 7'd25;
         4'd4:  amp = 7'd33;
         4'd5:  amp = 7'd42;
         4'd6:  amp = 7'd50;
         4'd7:  amp = 7'd59;
         4'd8:  amp = 7'd67;
         4'd9:  amp = 7'd76;
         4'd10: amp = 7'd84;
         4'd11: amp = 7'd93;
         4'd12: amp = 7'd101;
         4'd13: amp = 7'd110;
         4'd14: amp = 7'd118;
         4'd15: amp = 7'd127;
      endcase
      return amp;
   endfunction

endpackage

// File: rtl/core/psg_square_noise_synth_unit.sv
`timescale 1ns / 1ps
// Three-voice square wave plus LFSR noise synthesizer, one 8-bit DAC sample per tick.
// Request channel (req_*): cmd 0 writes reg_value into chip register reg_index,
// cmd 1 recomputes the cached voice steps and noise interval, cmd 2 is a sample
// tick. cmd 3 is ignored. Only a tick returns a beat on the response channel (rsp_*).
// Configuration (csr_*): index 0 sample rate, 1 master volume, 2 audio enable;
// write only while the block is idle. csr_ready is high outside reset.
// A register write leaves the block idle. A tick holds req_stall while the voices step
// one after another through the shared phase adder, then the noise, the master volume
// multiply and the sample hand-off; rsp_valid is registered out of the hand-off step.
// With audio disabled a tick skips to the hand-off and answers 128. A recompute walks
// the voices and the noise through one restoring divider at one quotient bit per
// cycle; each live slot is fetched, set up, divided and stored, and a silent slot is
// only fetched and set up.
// Reset (synchronous) restores the reset values of control, configuration and synth state.
// A stalled response holds in the output register; the next request is still
// taken, and a tick that finishes while the output is full waits for it to drain.
module psg_square_noise_synth_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [psg_pkg::CMD_W-1:0]         req_cmd,
   input  logic [psg_pkg::REG_IDX_W-1:0]     req_reg_index,
   input  logic [psg_pkg::BYTE_W-1:0]        req_reg_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [psg_pkg::BYTE_W-1:0]        rsp_dac_sample,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psg_pkg::CSR_DATA_W-1:0]    csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SETUP,
      ST_DIVIDE,
      ST_STORE,
      ST_VOICE,
      ST_NOISE,
      ST_SCALE,
      ST_DONE
   } state_type;

   localparam logic [psg_pkg::VI_W-1:0] NOISE_SLOT = psg_pkg::VI_W'(psg_pkg::VOICES);
   localparam logic [psg_pkg::VI_W-1:0] LAST_VOICE = psg_pkg::VI_W'(psg_pkg::VOICES - 1);
   localparam logic [psg_pkg::DIV_CNT_W-1:0] DIV_LAST =
      psg_pkg::DIV_CNT_W'(psg_pkg::DIV_STEPS - 1);

   // chip register file
   logic [psg_pkg::BYTE_W-1:0]    chip_mem [16];
   logic [15:0]                   chip_vld_ff;
   logic [psg_pkg::REG_IDX_W-1:0] rd_addr;
   logic [psg_pkg::BYTE_W-1:0]    rd_data_ff;
   logic                          rd_vld_ff;
   logic [psg_pkg::BYTE_W-1:0]    rd_data;

   logic req_take;
   logic chip_we;
   logic csr_take;

   state_type state_ff, state_in;
   logic [psg_pkg::VI_W-1:0] vi_ff, vi_in;
   logic [2:0]               fc_ff, fc_in;

   // configuration
   logic [psg_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [psg_pkg::BYTE_W-1:0] mvol_ff, mvol_in;
   logic                       enable_ff, enable_in;

   // cached voice settings and tone state
   logic [psg_pkg::LEVEL_W-1:0] voice_level_ff [psg_pkg::VOICES];
   logic [psg_pkg::LEVEL_W-1:0] voice_level_in [psg_pkg::VOICES];
   logic [psg_pkg::STEP_W-1:0]  voice_step_ff  [psg_pkg::VOICES];
   logic [psg_pkg::STEP_W-1:0]  voice_step_in  [psg_pkg::VOICES];
   logic [psg_pkg::STEP_W-1:0]  voice_phase_ff [psg_pkg::VOICES];
   logic [psg_pkg::STEP_W-1:0]  voice_phase_in [psg_pkg::VOICES];

   logic [psg_pkg::NSHIFT_W-1:0] noise_shift_ff, noise_shift_in;
   logic [psg_pkg::NCOUNT_W-1:0] noise_count_ff, noise_count_in;
   logic [psg_pkg::NCOUNT_W-1:0] noise_iv_ff, noise_iv_in;
   logic [psg_pkg::NSIGN_W-1:0]  noise_sign_ff, noise_sign_in;
   logic [psg_pkg::LEVEL_W-1:0]  noise_level_ff, noise_level_in;

   // fetched chip bytes for the slot at hand
   logic [psg_pkg::BYTE_W-1:0]  per_lo_ff, per_lo_in;
   logic [3:0]                  per_hi_ff, per_hi_in;
   logic [psg_pkg::LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [psg_pkg::BYTE_W-1:0]  mixer_ff, mixer_in;

   // shared divider
   logic [psg_pkg::DIV_NUM_W-1:0] div_num_ff, div_num_in;
   logic [psg_pkg::DIV_DEN_W-1:0] div_den_ff, div_den_in;
   logic [psg_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [psg_pkg::STEP_W-1:0]    quo_ff, quo_in;
   logic [psg_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // tick datapath
   logic signed [psg_pkg::MIX_W-1:0]  mix_ff, mix_in;
   logic signed [psg_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [psg_pkg::BYTE_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_stall      = reset || (state_ff != ST_IDLE);
   assign req_take       = req_valid && !req_stall;
   assign chip_we        = req_take && (req_cmd == psg_pkg::CMD_WRITE);
   assign csr_ready      = !reset;
   assign csr_take       = csr_valid && csr_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dac_sample = rsp_data_ff;
   assign rd_data        = rd_vld_ff ? rd_data_ff : '0;

   // fetch order per slot: period low, period high, level, mixer
   always_comb begin
      unique case (fc_ff[1:0])
         2'd0: rd_addr = (vi_ff == NOISE_SLOT) ? psg_pkg::REG_NOISE_PERIOD
                                                : psg_pkg::REG_IDX_W'({vi_ff, 1'b0});
         2'd1: rd_addr = (vi_ff == NOISE_SLOT) ? psg_pkg::REG_NOISE_PERIOD
                                                : psg_pkg::REG_IDX_W'({vi_ff, 1'b1});
         2'd2: rd_addr = (vi_ff == NOISE_SLOT) ? psg_pkg::REG_LEVEL_BASE
                                                : psg_pkg::REG_LEVEL_BASE
                                                  + psg_pkg::REG_IDX_W'(vi_ff);
         2'd3: rd_addr = psg_pkg::REG_MIXER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (chip_we) begin
         chip_mem[req_reg_index] <= req_reg_value;
      end
      rd_data_ff <= chip_mem[rd_addr];
   end

   always_comb begin
      logic [psg_pkg::PERIOD_W-1:0]  period;
      logic [psg_pkg::NPER_W-1:0]    nper;
      logic [psg_pkg::PERIOD_W-1:0]  mul_b;
      logic [psg_pkg::DIV_DEN_W-1:0] mul_p;
      logic                          live;
      logic [psg_pkg::DIV_DEN_W:0]   rem_sh;
      logic [psg_pkg::DIV_DEN_W:0]   rem_sub;
      logic                          rem_ge;
      logic [psg_pkg::STEP_W-1:0]    phase_sum;
      logic signed [psg_pkg::MIX_W-1:0] amp;
      logic [psg_pkg::NCOUNT_W-1:0]  cnt_inc;
      logic [psg_pkg::NSIGN_W-1:0]   sign_v;
      logic signed [7:0]             mix_q;
      logic signed [11:0]            dac_val;
      logic [psg_pkg::BYTE_W-1:0]    sample;

      state_in       = state_ff;
      vi_in          = vi_ff;
      fc_in          = fc_ff;
      rate_in        = rate_ff;
      mvol_in        = mvol_ff;
      enable_in      = enable_ff;
      voice_level_in = voice_level_ff;
      voice_step_in  = voice_step_ff;
      voice_phase_in = voice_phase_ff;
      noise_shift_in = noise_shift_ff;
      noise_count_in = noise_count_ff;
      noise_iv_in    = noise_iv_ff;
      noise_sign_in  = noise_sign_ff;
      noise_level_in = noise_level_ff;
      per_lo_in      = per_lo_ff;
      per_hi_in      = per_hi_ff;
      lvl_in         = lvl_ff;
      mixer_in       = mixer_ff;
      div_num_in     = div_num_ff;
      div_den_in     = div_den_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_cnt_in     = div_cnt_ff;
      mix_in         = mix_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      period    = {per_hi_ff, per_lo_ff};
      nper      = per_lo_ff[psg_pkg::NPER_W-1:0];
      mul_b     = (vi_ff == NOISE_SLOT) ? psg_pkg::PERIOD_W'({nper, 4'b0000}) : period;
      mul_p     = rate_ff * mul_b;
      live      = 1'b0;
      rem_sh    = {rem_ff, div_num_ff[psg_pkg::DIV_NUM_W-1]};
      rem_sub   = rem_sh - {1'b0, div_den_ff};
      rem_ge    = rem_sh >= {1'b0, div_den_ff};
      phase_sum = '0;
      amp       = '0;
      cnt_inc   = noise_count_ff + 16'd1;
      sign_v    = noise_sign_ff;
      mix_q     = mix_ff[psg_pkg::MIX_W-1:2];
      dac_val   = {prod_ff[psg_pkg::PROD_W-1], prod_ff[psg_pkg::PROD_W-1:6]} + 12'sd128;
      if (dac_val[11]) begin
         sample = '0;
      end else if (dac_val > 12'sd255) begin
         sample = 8'd255;
      end else begin
         sample = dac_val[7:0];
      end

      if (csr_take) begin
         unique case (csr_index)
            psg_pkg::CSR_SAMPLE_RATE:   rate_in   = csr_data;
            psg_pkg::CSR_MASTER_VOLUME: mvol_in   = csr_data[psg_pkg::BYTE_W-1:0];
            psg_pkg::CSR_AUDIO_ENABLE:  enable_in = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_cmd)
                  psg_pkg::CMD_RECOMPUTE: begin
                     vi_in    = '0;
                     fc_in    = '0;
                     state_in = ST_FETCH;
                  end
                  psg_pkg::CMD_TICK: begin
                     vi_in  = '0;
                     mix_in = '0;
                     if (enable_ff) begin
                        state_in = ST_VOICE;
                     end else begin
                        prod_in  = '0;
                        state_in = ST_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_FETCH: begin
            // read data is registered and arrives the cycle after its address
            fc_in = fc_ff + 3'd1;
            unique case (fc_ff)
               3'd1: per_lo_in = rd_data;
               3'd2: per_hi_in = rd_data[3:0];
               3'd3: lvl_in    = rd_data[psg_pkg::LEVEL_W-1:0];
               3'd4: begin
                  mixer_in = rd_data;
                  fc_in    = '0;
                  state_in = ST_SETUP;
               end
               default: ;
            endcase
         end

         ST_SETUP: begin
            rem_in     = '0;
            quo_in     = '0;
            div_cnt_in = '0;
            if (vi_ff == NOISE_SLOT) begin
               live = (mixer_ff[5:3] != 3'b111) && (nper != '0);
               if (live) begin
                  noise_level_in = lvl_ff;
                  if (psg_pkg::PERIOD_W'(nper) > psg_pkg::FAST_PERIOD) begin
                     div_num_in = psg_pkg::DIV_NUM_W'(mul_p);
                     div_den_in = psg_pkg::DIV_DEN_W'(psg_pkg::CHIP_CLOCK);
                  end else begin
                     div_num_in = psg_pkg::DIV_NUM_W'(rate_ff);
                     div_den_in = psg_pkg::DIV_DEN_W'(psg_pkg::TOP_FREQ);
                  end
                  state_in = ST_DIVIDE;
               end else begin
                  noise_level_in = '0;
                  state_in       = ST_IDLE;
               end
            end else begin
               live = !mixer_ff[3'(vi_ff)] && (period != '0) && (lvl_ff != '0);
               if (!live) begin
                  voice_level_in[vi_ff] = '0;
                  voice_step_in[vi_ff]  = '0;
                  vi_in                 = vi_ff + 1'b1;
                  state_in              = ST_FETCH;
               end else begin
                  voice_level_in[vi_ff] = lvl_ff;
                  if (rate_ff == '0) begin
                     voice_step_in[vi_ff] = '0;
                     vi_in                = vi_ff + 1'b1;
                     state_in             = ST_FETCH;
                  end else begin
                     if (period > psg_pkg::FAST_PERIOD) begin
                        div_num_in = psg_pkg::VOICE_NUM;
                        div_den_in = mul_p;
                     end else begin
                        div_num_in = psg_pkg::TOP_NUM;
                        div_den_in = psg_pkg::DIV_DEN_W'(rate_ff);
                     end
                     state_in = ST_DIVIDE;
                  end
               end
            end
         end

         ST_DIVIDE: begin
            // restoring division, one quotient bit per cycle; only the low 32 bits stay
            rem_in     = rem_ge ? rem_sub[psg_pkg::DIV_DEN_W-1:0]
                                : rem_sh[psg_pkg::DIV_DEN_W-1:0];
            quo_in     = {quo_ff[psg_pkg::STEP_W-2:0], rem_ge};
            div_num_in = div_num_ff << 1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_STORE;
            end
         end

         ST_STORE: begin
            if (vi_ff == NOISE_SLOT) begin
               noise_iv_in = (quo_ff == '0) ? psg_pkg::NCOUNT_W'(1)
                                            : quo_ff[psg_pkg::NCOUNT_W-1:0];
               state_in    = ST_IDLE;
            end else begin
               voice_step_in[vi_ff] = quo_ff;
               vi_in                = vi_ff + 1'b1;
               state_in             = ST_FETCH;
            end
         end

         ST_VOICE: begin
            if ((voice_step_ff[vi_ff] != '0) && (voice_level_ff[vi_ff] != '0)) begin
               phase_sum             = voice_phase_ff[vi_ff] + voice_step_ff[vi_ff];
               voice_phase_in[vi_ff] = phase_sum;
               amp = $signed({3'b000, psg_pkg::level_amp(voice_level_ff[vi_ff])});
               mix_in = phase_sum[psg_pkg::STEP_W-1] ? (mix_ff + amp) : (mix_ff - amp);
            end
            if (vi_ff == LAST_VOICE) begin
               state_in = ST_NOISE;
            end else begin
               vi_in = vi_ff + 1'b1;
            end
         end

         ST_NOISE: begin
            if ((noise_level_ff != '0) && (noise_iv_ff != '0)) begin
               amp = $signed({3'b000, psg_pkg::level_amp(noise_level_ff)});
               if (cnt_inc >= noise_iv_ff) begin
                  noise_count_in = '0;
                  noise_shift_in = {noise_shift_ff[0] ^ noise_shift_ff[3],
                                    noise_shift_ff[psg_pkg::NSHIFT_W-1:1]};
                  sign_v = noise_shift_ff[1] ? psg_pkg::NSIGN_PLUS : psg_pkg::NSIGN_MINUS;
               end else begin
                  noise_count_in = cnt_inc;
               end
               noise_sign_in = sign_v;
               if (sign_v == psg_pkg::NSIGN_PLUS) begin
                  mix_in = mix_ff + amp;
               end else if (sign_v == psg_pkg::NSIGN_MINUS) begin
                  mix_in = mix_ff - amp;
               end
            end
            state_in = ST_SCALE;
         end

         ST_SCALE: begin
            prod_in  = mix_q * $signed({1'b0, mvol_ff});
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sample;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      per_lo_ff  <= per_lo_in;
      per_hi_ff  <= per_hi_in;
      lvl_ff     <= lvl_in;
      mixer_ff   <= mixer_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
      mix_ff     <= mix_in;
      prod_ff    <= prod_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         vi_ff          <= '0;
         fc_ff          <= '0;
         rate_ff        <= psg_pkg::RATE_RESET;
         mvol_ff        <= psg_pkg::MVOL_RESET;
         enable_ff      <= 1'b0;
         voice_level_ff <= '{default: '0};
         voice_step_ff  <= '{default: '0};
         voice_phase_ff <= '{default: '0};
         noise_shift_ff <= psg_pkg::NOISE_SEED;
         noise_count_ff <= '0;
         noise_iv_ff    <= psg_pkg::NOISE_IV_RESET;
         noise_sign_ff  <= psg_pkg::NSIGN_NONE;
         noise_level_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         chip_vld_ff    <= '0;
         rd_vld_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         vi_ff          <= vi_in;
         fc_ff          <= fc_in;
         rate_ff        <= rate_in;
         mvol_ff        <= mvol_in;
         enable_ff      <= enable_in;
         voice_level_ff <= voice_level_in;
         voice_step_ff  <= voice_step_in;
         voice_phase_ff <= voice_phase_in;
         noise_shift_ff <= noise_shift_in;
         noise_count_ff <= noise_count_in;
         noise_iv_ff    <= noise_iv_in;
         noise_sign_ff  <= noise_sign_in;
         noise_level_ff <= noise_level_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (chip_we) begin
            chip_vld_ff[req_reg_index] <= 1'b1;
         end
         rd_vld_ff      <= chip_vld_ff[rd_addr];
      end
   end

endmodule

// File: rtl/core/psg_sva_checker.sv
`timescale 1ns / 1ps
module psg_sva_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [psg_pkg::CMD_W-1:0]     req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [psg_pkg::BYTE_W-1:0]    rsp_dac_sample
);

   // no response beat survives reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dac_sample))
      else $error("stalled response beat changed");

   // ticks and recomputes keep the block busy: the request side stalls right after
   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && (req_cmd == psg_pkg::CMD_TICK || req_cmd == psg_pkg::CMD_RECOMPUTE)
      |=> req_stall)
      else $error("block not busy after tick or recompute");

   // a register write leaves the block idle: no stall follows it
   a_write_single_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == psg_pkg::CMD_WRITE |=> !req_stall)
      else $error("register write left the block busy");

   // a new response beat only comes out of a tick in progress
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response beat appeared while idle");

endmodule

bind psg_square_noise_synth_unit psg_sva_checker u_psg_sva_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_dac_sample (rsp_dac_sample)
);

// File: sim/tb_psg_square_noise_synth_unit.sv
`timescale 1ns / 1ps
module tb_psg_square_noise_synth_unit;

   localparam int          SETTLE_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam logic [psg_pkg::CMD_W-1:0]     CMD_UNUSED = 2'd3;
   localparam logic [psg_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [psg_pkg::CMD_W-1:0]      req_cmd;
   logic [psg_pkg::REG_IDX_W-1:0]  req_reg_index;
   logic [psg_pkg::BYTE_W-1:0]     req_reg_value;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [psg_pkg::BYTE_W-1:0]     rsp_dac_sample;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [psg_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [psg_pkg::CSR_DATA_W-1:0] csr_data;

   psg_square_noise_synth_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_reg_index  (req_reg_index),
      .req_reg_value  (req_reg_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_dac_sample (rsp_dac_sample),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // synth state mirror
   logic [psg_pkg::BYTE_W-1:0]   chip_regs [16];
   logic [psg_pkg::LEVEL_W-1:0]  voice_level [psg_pkg::VOICES];
   logic [psg_pkg::STEP_W-1:0]   voice_step [psg_pkg::VOICES];
   logic [psg_pkg::STEP_W-1:0]   voice_phase [psg_pkg::VOICES];
   logic [psg_pkg::NSHIFT_W-1:0] noise_shift;
   logic [psg_pkg::NCOUNT_W-1:0] noise_count;
   logic [psg_pkg::NCOUNT_W-1:0] noise_interval;
   logic [psg_pkg::NSIGN_W-1:0]  noise_sign;
   logic [psg_pkg::LEVEL_W-1:0]  noise_level;
   logic [psg_pkg::RATE_W-1:0]   cfg_rate;
   logic [psg_pkg::BYTE_W-1:0]   cfg_volume;
   logic                         cfg_enable;

   logic [psg_pkg::BYTE_W-1:0]   dac_expected [$];
   logic [psg_pkg::BYTE_W-1:0]   dac_want;
   int                           fault_count = 0;
   int unsigned                  cycle_count;
   bit                           tail_unthrottled = 1'b0;
   bit                           sender_calm = 1'b0;

   function automatic void reset_synth_state();
      int i;
      for (i = 0; i < 16; i++) chip_regs[i] = '0;
      for (i = 0; i < psg_pkg::VOICES; i++) begin
         voice_level[i] = '0;
         voice_step[i]  = '0;
         voice_phase[i] = '0;
      end
      noise_shift    = psg_pkg::NOISE_SEED;
      noise_count    = '0;
      noise_interval = psg_pkg::NOISE_IV_RESET;
      noise_sign     = psg_pkg::NSIGN_NONE;
      noise_level    = '0;
      cfg_rate       = psg_pkg::RATE_RESET;
      cfg_volume     = psg_pkg::MVOL_RESET;
      cfg_enable     = 1'b0;
   endfunction

   function automatic void refresh_voices();
      logic [psg_pkg::BYTE_W-1:0]   mixer;
      logic [psg_pkg::PERIOD_W-1:0] period;
      logic [psg_pkg::LEVEL_W-1:0]  level;
      logic [psg_pkg::NPER_W-1:0]   nper;
      longint unsigned              rate, quo, clk_num, top_num;
      int                           v;
      mixer   = chip_regs[psg_pkg::REG_MIXER];
      rate    = 64'(cfg_rate);
      clk_num = 64'(psg_pkg::CHIP_CLOCK) << 28;
      top_num = 64'(psg_pkg::TOP_FREQ) << 32;
      for (v = 0; v < psg_pkg::VOICES; v++) begin
         period = {chip_regs[2*v+1][3:0], chip_regs[2*v]};
         level  = chip_regs[psg_pkg::REG_LEVEL_BASE + v][3:0];
         if (!mixer[v] && period != 0 && level != 0) begin
            quo = 0;
            if (rate != 0)
               quo = (period > psg_pkg::FAST_PERIOD) ? clk_num / (64'(period) * rate)
                                                     : top_num / rate;
            voice_level[v] = level;
            // oversized steps keep their low word
            voice_step[v]  = quo[31:0];
         end else begin
            voice_level[v] = '0;
            voice_step[v]  = '0;
         end
      end
      nper = chip_regs[psg_pkg::REG_NOISE_PERIOD][4:0];
      if (mixer[5:3] != 3'b111 && nper != 0) begin
         if (nper > psg_pkg::FAST_PERIOD)
            quo = (rate * 64'd16 * 64'(nper)) / 64'(psg_pkg::CHIP_CLOCK);
         else
            quo = rate / 64'(psg_pkg::TOP_FREQ);
         if (quo < 1) quo = 1;
         noise_interval = quo[15:0];
         noise_level    = chip_regs[psg_pkg::REG_LEVEL_BASE][3:0];
      end else begin
         noise_level = '0;
      end
   endfunction

   function automatic logic [psg_pkg::BYTE_W-1:0] synth_tick();
      int   mix, amp, level;
      int   v;
      logic fb;
      if (!cfg_enable) return psg_pkg::DAC_MID;
      mix = 0;
      for (v = 0; v < psg_pkg::VOICES; v++) begin
         if (voice_step[v] != 0 && voice_level[v] != 0) begin
            level = int'(voice_level[v]);
            amp   = level * 127 / 15;
            voice_phase[v] = voice_phase[v] + voice_step[v];
            mix = voice_phase[v][31] ? mix + amp : mix - amp;
         end
      end
      if (noise_level != 0 && noise_interval != 0) begin
         level = int'(noise_level);
         amp   = level * 127 / 15;
         noise_count = noise_count + 1'b1;
         if (noise_count >= noise_interval) begin
            fb          = noise_shift[0] ^ noise_shift[3];
            noise_count = '0;
            noise_shift = {fb, noise_shift[psg_pkg::NSHIFT_W-1:1]};
            noise_sign  = noise_shift[0] ? psg_pkg::NSIGN_PLUS : psg_pkg::NSIGN_MINUS;
         end
         if (noise_sign == psg_pkg::NSIGN_PLUS)
            mix = mix + amp;
         else if (noise_sign == psg_pkg::NSIGN_MINUS)
            mix = mix - amp;
      end
      mix = mix >>> 2;
      mix = mix * int'(cfg_volume);
      mix = mix >>> 6;
      mix = mix + 128;
      if (mix > 255) mix = 255;
      else if (mix < 0) mix = 0;
      return 8'(mix);
   endfunction

   // one request beat; valid stays up after acceptance unless the caller drops it
   task automatic send_item(input logic [psg_pkg::CMD_W-1:0] cmd,
                            input logic [psg_pkg::REG_IDX_W-1:0] idx,
                            input logic [psg_pkg::BYTE_W-1:0] val);
      if (!tail_unthrottled && !sender_calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_reg_index <= idx;
      req_reg_value <= val;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      case (cmd)
         psg_pkg::CMD_WRITE:     chip_regs[idx] = val;
         psg_pkg::CMD_RECOMPUTE: refresh_voices();
         psg_pkg::CMD_TICK:      dac_expected.push_back(synth_tick());
         default: ;
      endcase
   endtask

   task automatic wait_for_samples();
      req_valid <= 1'b0;
      @(posedge clock);
      while (dac_expected.size() != 0) @(posedge clock);
   endtask

   // writes and recomputes leave no beat behind, so give them time to finish
   task automatic settle_idle();
      wait_for_samples();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [psg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [psg_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         psg_pkg::CSR_SAMPLE_RATE:   cfg_rate   = data;
         psg_pkg::CSR_MASTER_VOLUME: cfg_volume = data[7:0];
         psg_pkg::CSR_AUDIO_ENABLE:  cfg_enable = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [psg_pkg::RATE_W-1:0] rate,
                             input logic [psg_pkg::BYTE_W-1:0] volume,
                             input logic enable);
      csr_write(psg_pkg::CSR_SAMPLE_RATE, rate);
      csr_write(psg_pkg::CSR_MASTER_VOLUME, {8'($urandom), volume});
      csr_write(psg_pkg::CSR_AUDIO_ENABLE, {15'($urandom), enable});
      csr_write(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic write_random_reg();
      logic [psg_pkg::REG_IDX_W-1:0] idx;
      logic [psg_pkg::BYTE_W-1:0]    val;
      idx = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
      val = 8'($urandom);
      // favor short periods now and then
      if (idx < psg_pkg::REG_NOISE_PERIOD && $urandom_range(0, 2) == 0)
         val = idx[0] ? {val[7:4], 4'h0} : 8'($urandom_range(1, 30));
      send_item(psg_pkg::CMD_WRITE, idx, val);
   endtask

   // mostly: a few register writes, a recompute, then a run of ticks
   task automatic run_programs(input int beats);
      int                        sent, n, kind;
      logic [psg_pkg::CMD_W-1:0] cmd;
      sent = 0;
      while (sent < beats) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            n = $urandom_range(1, 6);
            repeat (n) write_random_reg();
            send_item(psg_pkg::CMD_RECOMPUTE, 4'($urandom), 8'($urandom));
            sent += n + 1;
            n = $urandom_range(2, 24);
            repeat (n) begin
               if ($urandom_range(0, 15) == 0)
                  send_item(CMD_UNUSED, 4'($urandom), 8'($urandom));
               send_item(psg_pkg::CMD_TICK, 4'($urandom), 8'($urandom));
            end
            sent += n;
         end else if (kind == 7) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               cmd = 2'($urandom);
               send_item(cmd, 4'($urandom), 8'($urandom));
               if (cmd != CMD_UNUSED) sent++;
            end
         end else if (kind == 8) begin
            // stale settings: write without recompute
            write_random_reg();
            n = $urandom_range(1, 8);
            repeat (n) send_item(psg_pkg::CMD_TICK, 4'($urandom), 8'($urandom));
            sent += n + 1;
         end else begin
            wait_for_samples();
         end
      end
   endtask

   task automatic run_phase(input logic [psg_pkg::RATE_W-1:0] rate,
                            input logic [psg_pkg::BYTE_W-1:0] volume,
                            input logic enable, input int beats);
      settle_idle();
      set_config(rate, volume, enable);
      run_programs(beats);
   endtask

   task automatic test_disabled_after_reset();
      send_item(psg_pkg::CMD_WRITE, psg_pkg::REG_LEVEL_BASE, 8'h0F);
      send_item(psg_pkg::CMD_RECOMPUTE, 4'h0, 8'h00);
      send_item(psg_pkg::CMD_TICK, 4'hF, 8'hFF);
      send_item(psg_pkg::CMD_TICK, 4'h0, 8'h00);
   endtask

   task automatic test_directed_voices();
      settle_idle();
      set_config(16'd22050, 8'd64, 1'b1);
      send_item(psg_pkg::CMD_WRITE, 4'd0, 8'd22);     // A: period 22, fast path
      send_item(psg_pkg::CMD_WRITE, 4'd1, 8'hF0);     // upper nibble ignored
      send_item(psg_pkg::CMD_WRITE, 4'd2, 8'hFF);     // B: period 4095
      send_item(psg_pkg::CMD_WRITE, 4'd3, 8'hFF);
      send_item(psg_pkg::CMD_WRITE, 4'd4, 8'd23);     // C: first divided period
      send_item(psg_pkg::CMD_WRITE, 4'd5, 8'h00);
      send_item(psg_pkg::CMD_WRITE, psg_pkg::REG_NOISE_PERIOD, 8'hFF);
      send_item(psg_pkg::CMD_WRITE, psg_pkg::REG_MIXER, 8'hC0);
      send_item(psg_pkg::CMD_WRITE, 4'd8, 8'h1F);
      send_item(psg_pkg::CMD_WRITE, 4'd9, 8'h01);
      send_item(psg_pkg::CMD_WRITE, 4'd10, 8'h08);
      send_item(psg_pkg::CMD_RECOMPUTE, 4'h0, 8'h00);
      repeat (4) send_item(psg_pkg::CMD_TICK, 4'h0, 8'h00);
      send_item(CMD_UNUSED, 4'hF, 8'hFF);
      send_item(psg_pkg::CMD_WRITE, psg_pkg::REG_MIXER, 8'h3F);
      send_item(psg_pkg::CMD_TICK, 4'h0, 8'h00);
      send_item(psg_pkg::CMD_RECOMPUTE, 4'h0, 8'h00);
      send_item(psg_pkg::CMD_TICK, 4'h0, 8'h00);
      send_item(psg_pkg::CMD_WRITE, psg_pkg::REG_MIXER, 8'h37); // noise only
      send_item(psg_pkg::CMD_RECOMPUTE, 4'h0, 8'h00);
      repeat (2) send_item(psg_pkg::CMD_TICK, 4'h0, 8'h00);
   endtask

   task automatic test_rate_extremes();
      run_phase(16'd0, 8'd128, 1'b1, 130);      // zero rate: steps vanish
      run_phase(16'd1, 8'd200, 1'b1, 130);      // huge steps, fast path wraps to zero
      run_phase(16'd625, 8'd100, 1'b1, 130);
      run_phase(16'hFFFF, 8'd255, 1'b1, 130);
      run_phase(16'd8000, 8'd255, 1'b1, 130);
      run_phase(16'd48000, 8'd255, 1'b1, 130);
   endtask

   task automatic test_volume_extremes();
      run_phase(16'd22050, 8'd0, 1'b1, 130);
      run_phase(16'd22050, 8'd255, 1'b1, 130);
   endtask

   task automatic test_random_settings();
      repeat (3)
         run_phase(16'($urandom_range(8000, 48000)), 8'($urandom), 1'b1, 130);
      run_phase(16'($urandom), 8'($urandom), 1'b0, 40);
   endtask

   task automatic test_unthrottled_tail();
      tail_unthrottled = 1'b1;
      run_phase(16'd44100, 8'd160, 1'b1, 150);
   endtask

   // response side backpressure
   initial begin
      int open_left, hold_left;
      open_left = 5;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0)
            hold_left--;
         else if (open_left > 0)
            open_left--;
         else if (!tail_unthrottled) begin
            hold_left = $urandom_range(1, 18);
            open_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 30);
         end
         rsp_stall <= (hold_left > 0) && !tail_unthrottled;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (dac_expected.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected dac_sample beat: %0d", rsp_dac_sample);
         end else begin
            dac_want = dac_expected.pop_front();
            if (rsp_dac_sample !== dac_want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("dac_sample mismatch: expected %0d, got %0d", dac_want, rsp_dac_sample);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
               dac_expected.size());
      $display("** psg_square_noise_synth_unit: FAILED **");
      $finish;
   end

   initial begin
      req_valid     <= 1'b0;
      req_cmd       <= psg_pkg::CMD_WRITE;
      req_reg_index <= '0;
      req_reg_value <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= psg_pkg::CSR_SAMPLE_RATE;
      csr_data      <= '0;
      reset         <= 1'b1;
      reset_synth_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_disabled_after_reset();
      test_directed_voices();
      test_rate_extremes();
      test_volume_extremes();
      test_random_settings();
      test_unthrottled_tail();

      settle_idle();
      if (fault_count == 0)
         $display("** psg_square_noise_synth_unit: PASSED **");
      else
         $display("** psg_square_noise_synth_unit: FAILED **");
      $finish;
   end

endmodule
